>>> hw/rtl/preemptive_priority_task_queue_defines.svh
// ----------------------------------------------------------------------------
// Preemptive priority task queue assertion macros
// Concurrent assertion helpers clocked on clk_i and disabled while rst_ni is
// low. They expand to nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef PREEMPTIVE_PRIORITY_TASK_QUEUE_DEFINES_SVH
`define PREEMPTIVE_PRIORITY_TASK_QUEUE_DEFINES_SVH

`ifndef SYNTHESIS
`define PTQ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("task queue assertion failed");
`define PTQ_ASSERT_MSG(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);
`else
`define PTQ_ASSERT(lbl, prop)
`define PTQ_ASSERT_MSG(lbl, prop, msg)
`endif

`endif

>>> hw/rtl/ptq_pkg.sv
// ----------------------------------------------------------------------------
// Preemptive priority task queue package
// Shared codes, entry type and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package ptq_pkg;

  localparam int unsigned PrioW  = 7;
  localparam int unsigned HidW   = 8;
  localparam int unsigned EventW = 3;
  localparam int unsigned CountW = 5;

  localparam logic [PrioW-1:0] IDLE_LEVEL = 7'd100;

  typedef enum logic [1:0] {
    ACT_ADD      = 2'd0,
    ACT_DISPATCH = 2'd1,
    ACT_FINISH   = 2'd2
  } action_e;

  typedef enum logic [EventW-1:0] {
    EV_QUEUED       = 3'd0,
    EV_DROPPED      = 3'd1,
    EV_START        = 3'd2,
    EV_NOTHING      = 3'd3,
    EV_RESUMED      = 3'd4,
    EV_EMPTY_FINISH = 3'd5
  } event_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD_SCAN,
    ST_ADD_PUT,
    ST_DSP_CHK,
    ST_DSP_SHIFT,
    ST_FIN_POP,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [PrioW-1:0] prio;
    logic [HidW-1:0]  hid;
  } entry_t;

endpackage

`default_nettype wire

>>> hw/rtl/ptq_if.sv
// ----------------------------------------------------------------------------
// Preemptive priority task queue channels
// Valid/ready channels for task beats in and result beats out.
// ----------------------------------------------------------------------------
`default_nettype none

interface ptq_task_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [6:0] priority_req;
  logic [7:0] handler_id;

  modport source (output valid, output action, output priority_req,
                  output handler_id, input ready);
  modport sink   (input valid, input action, input priority_req,
                  input handler_id, output ready);
endinterface

interface ptq_result_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_res;
  logic [7:0] start_handler;
  logic [6:0] running_level;
  logic [4:0] queued_count;

  modport source (output valid, output event_res, output start_handler,
                  output running_level, output queued_count, input ready);
  modport sink   (input valid, input event_res, input start_handler,
                  input running_level, input queued_count, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/preemptive_priority_task_queue.sv
// ----------------------------------------------------------------------------
// Preemptive priority task queue
// Deferred-task scheduler with a sorted wait queue and a nesting save stack.
// ----------------------------------------------------------------------------
// The block takes one task beat at a time and returns exactly one result beat
// for it. An add inserts the handler behind every waiting task of equal or
// more urgent priority (lower number is more urgent), a dispatch starts the
// queue head when it beats the running level and the save stack has room,
// saving that level, and a finish restores the last saved level, or the idle
// level 100 when none is saved. The wait queue lives in a single-port-write
// RAM and is kept sorted by moving one entry per cycle. Results sit in an
// output register, so the next task beat is taken as soon as the sequencer
// is idle, even while a result still waits to be taken.
// ----------------------------------------------------------------------------
`default_nettype none

`include "preemptive_priority_task_queue_defines.svh"

module preemptive_priority_task_queue #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned NEST_DEPTH  = 16
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  ptq_task_if.sink         task_i,
  ptq_result_if.source     result_o
);

  // Counter widths hold the depth itself; address widths index the RAMs.
  localparam int unsigned QCW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned QAW = $clog2(QUEUE_DEPTH);
  localparam int unsigned NCW = $clog2(NEST_DEPTH + 1);
  localparam int unsigned NAW = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;

  localparam logic [QCW-1:0] QFULL = QCW'(QUEUE_DEPTH);
  localparam logic [NCW-1:0] NFULL = NCW'(NEST_DEPTH);
  localparam logic [QCW-1:0] QONE  = QCW'(1);
  localparam logic [NCW-1:0] NONE  = NCW'(1);

  // Sequencer and architectural state.
  ptq_pkg::state_e state_q, state_d;
  logic [QCW-1:0]  fill_q, fill_d;
  logic [NCW-1:0]  depth_q, depth_d;
  logic [ptq_pkg::PrioW-1:0] cur_q, cur_d;

  // Working registers for the item in flight.
  logic [QCW-1:0]            k_q, k_d;
  logic [ptq_pkg::PrioW-1:0] prio_q, prio_d;
  logic [ptq_pkg::HidW-1:0]  hid_q, hid_d;
  ptq_pkg::event_e           ev_q, ev_d;
  logic [ptq_pkg::HidW-1:0]  start_q, start_d;

  // Output register.
  logic                       ovalid_q, ovalid_d;
  ptq_pkg::event_e            oev_q, oev_d;
  logic [ptq_pkg::HidW-1:0]   ostart_q, ostart_d;
  logic [ptq_pkg::PrioW-1:0]  olevel_q, olevel_d;
  logic [ptq_pkg::CountW-1:0] ocount_q, ocount_d;

  // Wait queue RAM and save stack RAM, both with registered read data.
  ptq_pkg::entry_t q_mem [QUEUE_DEPTH];
  ptq_pkg::entry_t q_rd_q;
  logic            q_we, q_re;
  logic [QAW-1:0]  q_waddr, q_raddr;
  ptq_pkg::entry_t q_wdata;

  logic [ptq_pkg::PrioW-1:0] s_mem [NEST_DEPTH];
  logic [ptq_pkg::PrioW-1:0] s_rd_q;
  logic                      s_we, s_re;
  logic [NAW-1:0]            s_waddr, s_raddr;
  logic [ptq_pkg::PrioW-1:0] s_wdata;

  logic task_acc;
  logic out_free;
  logic [QCW-1:0] fill_m1, k_m1, k_m2, k_p1;
  logic [NCW-1:0] depth_m1;
  ptq_pkg::entry_t new_entry;

  assign task_i.ready = (state_q == ptq_pkg::ST_IDLE);
  assign task_acc     = task_i.valid && task_i.ready;
  assign out_free     = !ovalid_q || result_o.ready;

  assign fill_m1  = fill_q - QONE;
  assign k_m1     = k_q - QONE;
  assign k_m2     = k_q - QCW'(2);
  assign k_p1     = k_q + QONE;
  assign depth_m1 = depth_q - NONE;

  assign new_entry.prio = prio_q;
  assign new_entry.hid  = hid_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ptq_pkg::ST_IDLE: begin
        if (task_acc) begin
          case (task_i.action)
            ptq_pkg::ACT_ADD: begin
              if (fill_q == QFULL) begin
                state_d = ptq_pkg::ST_EMIT;
              end else if (fill_q == '0) begin
                state_d = ptq_pkg::ST_ADD_PUT;
              end else begin
                state_d = ptq_pkg::ST_ADD_SCAN;
              end
            end
            ptq_pkg::ACT_DISPATCH: begin
              state_d = (fill_q == '0) ? ptq_pkg::ST_EMIT : ptq_pkg::ST_DSP_CHK;
            end
            ptq_pkg::ACT_FINISH: begin
              state_d = (depth_q == '0) ? ptq_pkg::ST_EMIT : ptq_pkg::ST_FIN_POP;
            end
            default: begin
              state_d = ptq_pkg::ST_EMIT;
            end
          endcase
        end
      end
      ptq_pkg::ST_ADD_SCAN: begin
        if (q_rd_q.prio > prio_q) begin
          if (k_q == QONE) begin
            state_d = ptq_pkg::ST_ADD_PUT;
          end
        end else begin
          state_d = ptq_pkg::ST_EMIT;
        end
      end
      ptq_pkg::ST_ADD_PUT: begin
        state_d = ptq_pkg::ST_EMIT;
      end
      ptq_pkg::ST_DSP_CHK: begin
        if (q_rd_q.prio < cur_q && depth_q != NFULL && fill_q != QONE) begin
          state_d = ptq_pkg::ST_DSP_SHIFT;
        end else begin
          state_d = ptq_pkg::ST_EMIT;
        end
      end
      ptq_pkg::ST_DSP_SHIFT: begin
        if (k_q == fill_m1) begin
          state_d = ptq_pkg::ST_EMIT;
        end
      end
      ptq_pkg::ST_FIN_POP: begin
        state_d = ptq_pkg::ST_EMIT;
      end
      ptq_pkg::ST_EMIT: begin
        if (out_free) begin
          state_d = ptq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ptq_pkg::ST_IDLE;
      end
    endcase
  end

  // Datapath and RAM controls.
  always_comb begin
    fill_d   = fill_q;
    depth_d  = depth_q;
    cur_d    = cur_q;
    k_d      = k_q;
    prio_d   = prio_q;
    hid_d    = hid_q;
    ev_d     = ev_q;
    start_d  = start_q;
    ovalid_d = ovalid_q && !result_o.ready;
    oev_d    = oev_q;
    ostart_d = ostart_q;
    olevel_d = olevel_q;
    ocount_d = ocount_q;
    q_we     = 1'b0;
    q_waddr  = k_q[QAW-1:0];
    q_wdata  = new_entry;
    q_re     = 1'b0;
    q_raddr  = '0;
    s_we     = 1'b0;
    s_waddr  = depth_q[NAW-1:0];
    s_wdata  = cur_q;
    s_re     = 1'b0;
    s_raddr  = depth_m1[NAW-1:0];

    unique case (state_q)
      ptq_pkg::ST_IDLE: begin
        if (task_acc) begin
          prio_d  = task_i.priority_req;
          hid_d   = task_i.handler_id;
          start_d = '0;
          ev_d    = ptq_pkg::EV_NOTHING;
          case (task_i.action)
            ptq_pkg::ACT_ADD: begin
              k_d = fill_q;
              if (fill_q == QFULL) begin
                ev_d = ptq_pkg::EV_DROPPED;
              end else if (fill_q != '0) begin
                q_re    = 1'b1;
                q_raddr = fill_m1[QAW-1:0];
              end
            end
            ptq_pkg::ACT_DISPATCH: begin
              q_re    = (fill_q != '0);
              q_raddr = '0;
            end
            ptq_pkg::ACT_FINISH: begin
              if (depth_q == '0) begin
                cur_d = ptq_pkg::IDLE_LEVEL;
                ev_d  = ptq_pkg::EV_EMPTY_FINISH;
              end else begin
                s_re = 1'b1;
              end
            end
            default: begin
              ev_d = ptq_pkg::EV_NOTHING;
            end
          endcase
        end
      end
      ptq_pkg::ST_ADD_SCAN: begin
        // Read data holds entry k-1; move it up while it is less urgent.
        q_we    = 1'b1;
        q_waddr = k_q[QAW-1:0];
        if (q_rd_q.prio > prio_q) begin
          q_wdata = q_rd_q;
          k_d     = k_m1;
          q_re    = (k_q != QONE);
          q_raddr = k_m2[QAW-1:0];
        end else begin
          q_wdata = new_entry;
          fill_d  = fill_q + QONE;
          ev_d    = ptq_pkg::EV_QUEUED;
        end
      end
      ptq_pkg::ST_ADD_PUT: begin
        q_we    = 1'b1;
        q_waddr = k_q[QAW-1:0];
        q_wdata = new_entry;
        fill_d  = fill_q + QONE;
        ev_d    = ptq_pkg::EV_QUEUED;
      end
      ptq_pkg::ST_DSP_CHK: begin
        if (q_rd_q.prio < cur_q && depth_q != NFULL) begin
          s_we    = 1'b1;
          s_waddr = depth_q[NAW-1:0];
          s_wdata = cur_q;
          depth_d = depth_q + NONE;
          cur_d   = q_rd_q.prio;
          start_d = q_rd_q.hid;
          ev_d    = ptq_pkg::EV_START;
          k_d     = QONE;
          if (fill_q == QONE) begin
            fill_d = fill_m1;
          end else begin
            q_re    = 1'b1;
            q_raddr = QONE[QAW-1:0];
          end
        end
      end
      ptq_pkg::ST_DSP_SHIFT: begin
        // Read data holds entry k; it moves down one place.
        q_we    = 1'b1;
        q_waddr = k_m1[QAW-1:0];
        q_wdata = q_rd_q;
        if (k_q == fill_m1) begin
          fill_d = fill_m1;
        end else begin
          k_d     = k_p1;
          q_re    = 1'b1;
          q_raddr = k_p1[QAW-1:0];
        end
      end
      ptq_pkg::ST_FIN_POP: begin
        cur_d   = s_rd_q;
        depth_d = depth_m1;
        ev_d    = ptq_pkg::EV_RESUMED;
      end
      ptq_pkg::ST_EMIT: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          oev_d    = ev_q;
          ostart_d = start_q;
          olevel_d = cur_q;
          ocount_d = ptq_pkg::CountW'(fill_q);
        end
      end
      default: begin
        ev_d = ptq_pkg::EV_NOTHING;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ptq_pkg::ST_IDLE;
      fill_q   <= '0;
      depth_q  <= '0;
      cur_q    <= ptq_pkg::IDLE_LEVEL;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      fill_q   <= fill_d;
      depth_q  <= depth_d;
      cur_q    <= cur_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q      <= k_d;
    prio_q   <= prio_d;
    hid_q    <= hid_d;
    ev_q     <= ev_d;
    start_q  <= start_d;
    oev_q    <= oev_d;
    ostart_q <= ostart_d;
    olevel_q <= olevel_d;
    ocount_q <= ocount_d;
  end

  always_ff @(posedge clk_i) begin
    if (q_we) begin
      q_mem[q_waddr] <= q_wdata;
    end
    if (q_re) begin
      q_rd_q <= q_mem[q_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_we) begin
      s_mem[s_waddr] <= s_wdata;
    end
    if (s_re) begin
      s_rd_q <= s_mem[s_raddr];
    end
  end

  assign result_o.valid         = ovalid_q;
  assign result_o.event_res     = oev_q;
  assign result_o.start_handler = ostart_q;
  assign result_o.running_level = olevel_q;
  assign result_o.queued_count  = ocount_q;

  // Checks on the queue bookkeeping and the sequencer.
  `PTQ_ASSERT(a_fill_bound, fill_q <= QFULL)
  `PTQ_ASSERT(a_depth_bound, depth_q <= NFULL)
  `PTQ_ASSERT_MSG(a_level_bound, cur_q <= ptq_pkg::IDLE_LEVEL, "running level above idle")
  `PTQ_ASSERT_MSG(a_full_drop, task_acc && task_i.action == ptq_pkg::ACT_ADD && fill_q == QFULL |=> state_q == ptq_pkg::ST_EMIT && ev_q == ptq_pkg::EV_DROPPED && fill_q == QFULL, "add on full queue not dropped")
  `PTQ_ASSERT(a_emit_loads, state_q == ptq_pkg::ST_EMIT && out_free |=> state_q == ptq_pkg::ST_IDLE && ovalid_q)

endmodule

`default_nettype wire

>>> dv/preemptive_priority_task_queue_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Preemptive priority task queue testbench
// Drives task beats into the scheduler and checks every result beat against
// a cycle-free scheduling predictor: a short directed table first, then
// random bursts of mixed traffic, nesting ladders and queue fills.
// ----------------------------------------------------------------------------
module preemptive_priority_task_queue_test;

  localparam int unsigned QDEPTH = 16;
  localparam int unsigned NDEPTH = 16;

  // The action field is two bits wide; the top code is not an operation and
  // the block must leave its state alone when it sees it.
  localparam logic [1:0] ACT_IGNORED = 2'd3;

  localparam int TOTAL_ITEMS   = 1750;
  localparam int MAX_GAP       = 13;
  localparam int LONG_STALL_AT = 100;   // result beat at which the sink stalls
  localparam int LONG_STALL    = 400;   // length of that stall in cycles
  localparam int DRAIN_BURST   = 12;    // burst before which the source drains
  localparam int TAIL_CYCLES   = 40;
  localparam int CYCLE_LIMIT   = 500000;

  // One result beat as the block reports it.
  typedef struct packed {
    ptq_pkg::event_e            ev;
    logic [ptq_pkg::HidW-1:0]   hid;
    logic [ptq_pkg::PrioW-1:0]  lvl;
    logic [ptq_pkg::CountW-1:0] cnt;
  } outcome_t;

  // One row of the directed table. When typed is set, the expected result is
  // the one written in the row; otherwise the predictor supplies it.
  typedef struct packed {
    logic [1:0]                act;
    logic [ptq_pkg::PrioW-1:0] prio;
    logic [ptq_pkg::HidW-1:0]  hid;
    logic                      typed;
    outcome_t                  outcome;
  } dir_row_t;

  localparam int DIR_ROWS = 28;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  ptq_task_if   task_bus ();
  ptq_result_if result_bus ();

  preemptive_priority_task_queue #(
    .QUEUE_DEPTH(QDEPTH),
    .NEST_DEPTH (NDEPTH)
  ) u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .task_i  (task_bus),
    .result_o(result_bus)
  );

  always #1 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Scheduling predictor
  // --------------------------------------------------------------------------
  // Wait queue kept sorted by priority, equal priorities in arrival order.
  logic [ptq_pkg::PrioW-1:0] wait_prio [QDEPTH];
  logic [ptq_pkg::HidW-1:0]  wait_hid  [QDEPTH];
  int                        wait_fill = 0;
  // Running level and the stack of levels interrupted by nested dispatches.
  logic [ptq_pkg::PrioW-1:0] run_level = ptq_pkg::IDLE_LEVEL;
  logic [ptq_pkg::PrioW-1:0] level_stack [NDEPTH];
  int                        nest = 0;

  outcome_t pending_results [$];
  int       items_sent    = 0;
  int       beats_checked = 0;
  int       failures      = 0;
  int       cycles        = 0;
  bit       tx_quiet      = 1'b0;
  bit       rx_quiet      = 1'b0;

  // Advances the predictor by one task beat and returns the result it causes.
  function automatic outcome_t schedule_step(input logic [1:0]                act,
                                             input logic [ptq_pkg::PrioW-1:0] prio,
                                             input logic [ptq_pkg::HidW-1:0]  hid);
    outcome_t o;
    int pos;
    int k;
    o.ev  = ptq_pkg::EV_NOTHING;
    o.hid = '0;
    case (act)
      ptq_pkg::ACT_ADD: begin
        if (wait_fill >= QDEPTH) begin
          o.ev = ptq_pkg::EV_DROPPED;
        end else begin
          // Insert behind every entry that is not less urgent.
          pos = 0;
          while (pos < wait_fill && wait_prio[pos] <= prio) pos++;
          for (k = wait_fill; k > pos; k--) begin
            wait_prio[k] = wait_prio[k-1];
            wait_hid[k]  = wait_hid[k-1];
          end
          wait_prio[pos] = prio;
          wait_hid[pos]  = hid;
          wait_fill++;
          o.ev = ptq_pkg::EV_QUEUED;
        end
      end
      ptq_pkg::ACT_DISPATCH: begin
        // The head preempts only when strictly more urgent and there is room
        // to save the interrupted level.
        if (wait_fill != 0 && wait_prio[0] < run_level && nest < NDEPTH) begin
          level_stack[nest] = run_level;
          nest++;
          run_level = wait_prio[0];
          o.hid     = wait_hid[0];
          for (k = 1; k < wait_fill; k++) begin
            wait_prio[k-1] = wait_prio[k];
            wait_hid[k-1]  = wait_hid[k];
          end
          wait_fill--;
          o.ev = ptq_pkg::EV_START;
        end
      end
      ptq_pkg::ACT_FINISH: begin
        if (nest == 0) begin
          run_level = ptq_pkg::IDLE_LEVEL;
          o.ev      = ptq_pkg::EV_EMPTY_FINISH;
        end else begin
          nest--;
          run_level = level_stack[nest];
          o.ev      = ptq_pkg::EV_RESUMED;
        end
      end
      default: ;
    endcase
    o.lvl = run_level;
    o.cnt = ptq_pkg::CountW'(wait_fill);
    return o;
  endfunction

  // --------------------------------------------------------------------------
  // Task source
  // --------------------------------------------------------------------------
  // Offers one task beat, changing inputs only at the falling edge, and
  // records the expected result once the beat is accepted at a rising edge.
  task automatic offer_task(input logic [1:0]                act,
                            input logic [ptq_pkg::PrioW-1:0] prio,
                            input logic [ptq_pkg::HidW-1:0]  hid,
                            input logic                      typed,
                            input outcome_t                  typed_out);
    int gap;
    outcome_t predicted;
    gap = tx_quiet ? 0 : $urandom_range(0, MAX_GAP);
    @(negedge clk_i);
    if (gap != 0) begin
      task_bus.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    task_bus.valid        = 1'b1;
    task_bus.action       = act;
    task_bus.priority_req = prio;
    task_bus.handler_id   = hid;
    do @(posedge clk_i); while (!task_bus.ready);
    predicted = schedule_step(act, prio, hid);
    pending_results.push_back(typed ? typed_out : predicted);
    items_sent++;
  endtask

  // Withdraws the last beat and holds the source until every outstanding
  // result beat has been checked.
  task automatic drain_results();
    @(negedge clk_i);
    task_bus.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Directed table: empty-queue and empty-stack corners, the ignored action
  // code, a task that can never beat the idle level, a fill to the brim with
  // ties and a drop, then preemption and resume with FIFO order on ties.
  dir_row_t directed_plan [DIR_ROWS] = '{
    '{ptq_pkg::ACT_DISPATCH, 7'd0,   8'd0,   1'b1,
      '{ptq_pkg::EV_NOTHING,      8'd0, ptq_pkg::IDLE_LEVEL, 5'd0}},
    '{ptq_pkg::ACT_FINISH,   7'd0,   8'd0,   1'b1,
      '{ptq_pkg::EV_EMPTY_FINISH, 8'd0, ptq_pkg::IDLE_LEVEL, 5'd0}},
    '{ACT_IGNORED,           7'd127, 8'd255, 1'b1,
      '{ptq_pkg::EV_NOTHING,      8'd0, ptq_pkg::IDLE_LEVEL, 5'd0}},
    '{ptq_pkg::ACT_ADD,      7'd127, 8'd255, 1'b1,
      '{ptq_pkg::EV_QUEUED,       8'd0, ptq_pkg::IDLE_LEVEL, 5'd1}},
    '{ptq_pkg::ACT_DISPATCH, 7'd0,   8'd0,   1'b1,
      '{ptq_pkg::EV_NOTHING,      8'd0, ptq_pkg::IDLE_LEVEL, 5'd1}},
    '{ptq_pkg::ACT_ADD,      7'd0,   8'd0,   1'b1,
      '{ptq_pkg::EV_QUEUED,       8'd0, ptq_pkg::IDLE_LEVEL, 5'd2}},
    '{ptq_pkg::ACT_ADD,      7'd0,   8'd170, 1'b0, '0},
    '{ptq_pkg::ACT_ADD,      7'd100, 8'd85,  1'b0, '0},
    '{ptq_pkg::ACT_ADD,      7'd99,  8'd1,   1'b0, '0},
    '{ptq_pkg::ACT_ADD,      7'd64,  8'd128, 1'b0, '0},
    '{ptq_pkg::ACT_ADD,      7'd1,   8'd2,   1'b0, '0},
    '{ptq_pkg::ACT_ADD,      7'd50,  8'd15,  1'b0, '0},
    '{ptq_pkg::ACT_ADD,      7'd3,   8'd240, 1'b0, '0},
    '{ptq_pkg::ACT_ADD,      7'd0,   8'd51,  1'b0, '0},
    '{ptq_pkg::ACT_ADD,      7'd42,  8'd204, 1'b0, '0},
    '{ptq_pkg::ACT_ADD,      7'd99,  8'd85,  1'b0, '0},
    '{ptq_pkg::ACT_ADD,      7'd7,   8'd170, 1'b0, '0},
    '{ptq_pkg::ACT_ADD,      7'd63,  8'd1,   1'b0, '0},
    '{ptq_pkg::ACT_ADD,      7'd20,  8'd128, 1'b0, '0},
    '{ptq_pkg::ACT_ADD,      7'd31,  8'd254, 1'b0, '0},
    '{ptq_pkg::ACT_ADD,      7'd5,   8'd119, 1'b1,
      '{ptq_pkg::EV_DROPPED,      8'd0, ptq_pkg::IDLE_LEVEL, 5'd16}},
    '{ptq_pkg::ACT_DISPATCH, 7'd0,   8'd0,   1'b0, '0},
    '{ptq_pkg::ACT_DISPATCH, 7'd0,   8'd0,   1'b0, '0},
    '{ptq_pkg::ACT_FINISH,   7'd0,   8'd0,   1'b0, '0},
    '{ptq_pkg::ACT_DISPATCH, 7'd0,   8'd0,   1'b0, '0},
    '{ptq_pkg::ACT_DISPATCH, 7'd0,   8'd0,   1'b0, '0},
    '{ptq_pkg::ACT_FINISH,   7'd0,   8'd0,   1'b0, '0},
    '{ptq_pkg::ACT_FINISH,   7'd0,   8'd0,   1'b0, '0}
  };

  // Main sequence: reset, directed table, random bursts, then the final drain.
  initial begin
    int burst;
    int kind;
    int dead;
    int r;
    logic [ptq_pkg::PrioW-1:0] p;
    task_bus.valid        = 1'b0;
    task_bus.action       = ptq_pkg::ACT_ADD;
    task_bus.priority_req = '0;
    task_bus.handler_id   = '0;
    result_bus.ready      = 1'b0;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int i = 0; i < DIR_ROWS; i++) begin
      offer_task(directed_plan[i].act, directed_plan[i].prio, directed_plan[i].hid,
                 directed_plan[i].typed, directed_plan[i].outcome);
    end

    burst = 0;
    while (items_sent < TOTAL_ITEMS) begin
      // A quarter of the bursts run without any source gaps.
      tx_quiet = ($urandom_range(0, 3) == 0);
      // Once, let the block run completely dry before going on.
      if (burst == DRAIN_BURST) drain_results();
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        // Mixed traffic. Tasks at level 100 or above can never be dispatched
        // and would sit in the queue for good, so only a couple are allowed
        // to wait at any time.
        repeat (24) begin
          dead = 0;
          for (int k = 0; k < wait_fill; k++) begin
            if (wait_prio[k] >= ptq_pkg::IDLE_LEVEL) dead++;
          end
          r = $urandom_range(0, 99);
          if (dead < 2 && $urandom_range(0, 19) == 0)
            p = ptq_pkg::PrioW'($urandom_range(100, 127));
          else p = ptq_pkg::PrioW'($urandom_range(0, 99));
          if (r < 35)
            offer_task(ptq_pkg::ACT_ADD, p, ptq_pkg::HidW'($urandom_range(0, 255)),
                       1'b0, '0);
          else if (r < 70)
            offer_task(ptq_pkg::ACT_DISPATCH, ptq_pkg::PrioW'($urandom_range(0, 127)),
                       ptq_pkg::HidW'($urandom_range(0, 255)), 1'b0, '0);
          else if (r < 95)
            offer_task(ptq_pkg::ACT_FINISH, ptq_pkg::PrioW'($urandom_range(0, 127)),
                       ptq_pkg::HidW'($urandom_range(0, 255)), 1'b0, '0);
          else
            offer_task(ACT_IGNORED, ptq_pkg::PrioW'($urandom_range(0, 127)),
                       ptq_pkg::HidW'($urandom_range(0, 255)), 1'b0, '0);
        end
      end else if (kind < 9) begin
        // Nesting ladder: unwind to idle, flush every runnable task, then add
        // and dispatch ever more urgent tasks until the save stack is full.
        // The last dispatch finds the stack full and must leave the head queued.
        while (nest != 0) offer_task(ptq_pkg::ACT_FINISH, '0, '0, 1'b0, '0);
        offer_task(ptq_pkg::ACT_FINISH, '0, '0, 1'b0, '0);
        while (wait_fill != 0 && wait_prio[0] < run_level) begin
          offer_task(ptq_pkg::ACT_DISPATCH, '0, '0, 1'b0, '0);
          offer_task(ptq_pkg::ACT_FINISH, '0, '0, 1'b0, '0);
        end
        repeat (NDEPTH + 1) begin
          p = run_level - ptq_pkg::PrioW'($urandom_range(1, 3));
          offer_task(ptq_pkg::ACT_ADD, p, ptq_pkg::HidW'($urandom_range(0, 255)),
                     1'b0, '0);
          offer_task(ptq_pkg::ACT_DISPATCH, '0, '0, 1'b0, '0);
        end
      end else begin
        // Queue fill: add urgent tasks until full, then two that get dropped.
        while (wait_fill < QDEPTH)
          offer_task(ptq_pkg::ACT_ADD, ptq_pkg::PrioW'($urandom_range(0, 99)),
                     ptq_pkg::HidW'($urandom_range(0, 255)), 1'b0, '0);
        repeat (2)
          offer_task(ptq_pkg::ACT_ADD, ptq_pkg::PrioW'($urandom_range(0, 127)),
                     ptq_pkg::HidW'($urandom_range(0, 255)), 1'b0, '0);
      end
      burst++;
    end

    @(negedge clk_i);
    task_bus.valid = 1'b0;
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (failures == 0) begin
      $display("PASS preemptive_priority_task_queue");
    end else begin
      $display("FAIL preemptive_priority_task_queue");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result sink and checker
  // --------------------------------------------------------------------------
  // Ready changes at the falling edge. Each result beat is compared field by
  // field with the oldest expectation. Once during the run the sink holds off
  // for a long stretch so that the output register fills and the block stops
  // taking task beats while the source keeps offering them.
  initial begin
    int gap;
    outcome_t want;
    wait (rst_ni === 1'b1);
    forever begin
      if (beats_checked % 64 == 0) rx_quiet = ($urandom_range(0, 3) == 0);
      if (beats_checked == LONG_STALL_AT) gap = LONG_STALL;
      else gap = rx_quiet ? 0 : $urandom_range(0, MAX_GAP);
      @(negedge clk_i);
      if (gap != 0) begin
        result_bus.ready = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      result_bus.ready = 1'b1;
      do @(posedge clk_i); while (!result_bus.valid);
      if (pending_results.size() == 0) begin
        $display("%0t: result beat with nothing expected: event %0d handler %0d",
                 $time, result_bus.event_res, result_bus.start_handler);
        failures++;
      end else begin
        want = pending_results.pop_front();
        if (result_bus.event_res !== want.ev) begin
          $display("%0t: event expected %0d got %0d", $time, want.ev, result_bus.event_res);
          failures++;
        end
        if (result_bus.start_handler !== want.hid) begin
          $display("%0t: start handler expected %0d got %0d", $time, want.hid,
                   result_bus.start_handler);
          failures++;
        end
        if (result_bus.running_level !== want.lvl) begin
          $display("%0t: running level expected %0d got %0d", $time, want.lvl,
                   result_bus.running_level);
          failures++;
        end
        if (result_bus.queued_count !== want.cnt) begin
          $display("%0t: queued count expected %0d got %0d", $time, want.cnt,
                   result_bus.queued_count);
          failures++;
        end
      end
      beats_checked++;
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time,
               pending_results.size());
      $display("FAIL preemptive_priority_task_queue");
      $finish;
    end
  end

endmodule
